// ===== sv/pbt_pkg.sv =====
package pbt_pkg;

  // payload field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned ROOM_W   = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // packed stream widths
  localparam int unsigned S_DATA_W = 136;
  localparam int unsigned M_DATA_W = 80;

  // request kinds, carried on tuser
  localparam logic [KIND_W-1:0] KIND_REGISTER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AUTHORIZE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENUMERATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_DENIED    = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic in_load;   // capture the request
    logic cmp_load;  // register slot match vectors
    logic cnt_load;  // register match count
    logic decide;    // produce the first result, commit a register write
    logic emit_sel;  // walk the remaining enumerate matches
    logic step;      // produce the next enumerate result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic more;      // further enumerate results follow this one
  } sts_t;

endpackage

// ===== sv/pbt_ctrl.sv =====
module pbt_ctrl
  import pbt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    CMP,
    CNT,
    DEC,
    EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      IDLE: begin
        if (s_axis_tvalid && ready_q) begin
          cmd_o.in_load = 1'b1;
          state_d       = CMP;
        end
      end
      CMP: begin
        cmd_o.cmp_load = 1'b1;
        state_d        = CNT;
      end
      CNT: begin
        cmd_o.cnt_load = 1'b1;
        state_d        = DEC;
      end
      DEC: begin
        if (sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = sts_i.more ? EMIT : IDLE;
        end
      end
      EMIT: begin
        cmd_o.emit_sel = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          state_d    = sts_i.more ? EMIT : IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == IDLE);
    end
  end

  assign s_axis_tready = ready_q;

endmodule

// ===== sv/pbt_datapath.sv =====
module pbt_datapath
  import pbt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [KIND_W-1:0]   s_axis_tuser,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // request registers
  logic [KIND_W-1:0] kind_q;
  logic [ID_W-1:0]   app_q, type_q;
  logic [ROOM_W-1:0] room_q;

  // slot table
  logic [SLOTS-1:0] used_q;
  logic [ID_W-1:0]  app_mem_q  [SLOTS];
  logic [ID_W-1:0]  type_mem_q [SLOTS];
  logic [CW-1:0]    total_q;

  // match state
  logic [SLOTS-1:0] pair_hit_q, app_hit_q, rem_q;
  logic [SLOTS-1:0] pair_hit_d, app_hit_d;
  logic [CW-1:0]    count_q, count_d;

  // output register
  logic                m_valid_q;
  status_e             out_status_q;
  logic [ID_W-1:0]     out_type_q;
  logic [COUNT_W-1:0]  out_cnt_q, out_total_q;
  logic                out_last_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      app_hit_d[i]  = used_q[i] && (app_mem_q[i] == app_q);
      pair_hit_d[i] = app_hit_d[i] && (type_mem_q[i] == type_q);
    end
  end

  always_comb begin
    count_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      count_d = count_d + CW'(app_hit_q[i]);
    end
  end

  // lowest match of either the fresh vector or what is left of it
  logic [SLOTS-1:0] sel_src, sel_low, sel_rest;
  logic [IW-1:0]    sel_idx;
  logic [ID_W-1:0]  sel_type;

  assign sel_src  = cmd_i.emit_sel ? rem_q : app_hit_q;
  assign sel_low  = sel_src & (~sel_src + SLOTS'(1));
  assign sel_rest = sel_src & ~sel_low;

  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_low[i]) sel_idx = sel_idx | IW'(i);
    end
  end

  assign sel_type = type_mem_q[sel_idx];

  // lowest free slot
  logic [SLOTS-1:0] free_vec, free_low;
  logic             full;

  assign free_vec = ~used_q;
  assign free_low = free_vec & (~free_vec + SLOTS'(1));
  assign full     = &used_q;

  // decision for the first result of a request
  status_e         res_status;
  logic [ID_W-1:0] res_type;
  logic [CW-1:0]   res_cnt;
  logic            res_last;
  logic            wr_en;
  logic            enum_ok;
  logic            app_zero, type_zero, room_zero;

  assign app_zero  = (app_q == '0);
  assign type_zero = (type_q == '0);
  assign room_zero = (room_q == '0);

  always_comb begin
    res_status = ST_INVALID;
    res_type   = '0;
    res_cnt    = '0;
    res_last   = 1'b1;
    wr_en      = 1'b0;
    enum_ok    = 1'b0;
    unique case (kind_q)
      KIND_REGISTER: begin
        if (app_zero || type_zero)  res_status = ST_INVALID;
        else if (|pair_hit_q)       res_status = ST_EXISTS;
        else if (full)              res_status = ST_NO_SPACE;
        else begin
          res_status = ST_OK;
          wr_en      = 1'b1;
        end
      end
      KIND_AUTHORIZE: begin
        if (app_zero || type_zero)  res_status = ST_INVALID;
        else if (|pair_hit_q)       res_status = ST_OK;
        else                        res_status = ST_DENIED;
      end
      KIND_ENUMERATE: begin
        if (app_zero || room_zero) begin
          res_status = ST_INVALID;
        end else if (count_q == '0) begin
          res_status = ST_NOT_FOUND;
        end else if (8'(count_q) > 8'(room_q)) begin
          res_status = ST_NO_SPACE;
          res_cnt    = count_q;
        end else begin
          res_status = ST_OK;
          res_type   = sel_type;
          res_cnt    = count_q;
          res_last   = (sel_rest == '0);
          enum_ok    = 1'b1;
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  logic [CW-1:0] total_d;
  logic [7:0]    res_cnt_ext, count_ext, total_ext;

  assign total_d     = wr_en ? total_q + CW'(1) : total_q;
  assign res_cnt_ext = 8'(res_cnt);
  assign count_ext   = 8'(count_q);
  assign total_ext   = 8'(total_d);

  assign sts_o.out_free = !m_valid_q || m_axis_tready;
  assign sts_o.more     = (sel_rest != '0) && (cmd_i.emit_sel || enum_ok);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decide && wr_en) begin
        used_q  <= used_q | free_low;
        total_q <= total_d;
      end
      if (cmd_i.decide || cmd_i.step) m_valid_q <= 1'b1;
      else if (m_axis_tready)          m_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      app_q  <= s_axis_tdata[ID_W-1:0];
      type_q <= s_axis_tdata[2*ID_W-1:ID_W];
      room_q <= s_axis_tdata[2*ID_W+ROOM_W-1:2*ID_W];
      kind_q <= s_axis_tuser;
    end
    if (cmd_i.cmp_load) begin
      pair_hit_q <= pair_hit_d;
      app_hit_q  <= app_hit_d;
    end
    if (cmd_i.cnt_load) count_q <= count_d;
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd_i.decide && wr_en && free_low[i]) begin
        app_mem_q[i]  <= app_q;
        type_mem_q[i] <= type_q;
      end
    end
    if (cmd_i.decide) begin
      rem_q        <= sel_rest;
      out_status_q <= res_status;
      out_type_q   <= res_type;
      out_cnt_q    <= res_cnt_ext[COUNT_W-1:0];
      out_total_q  <= total_ext[COUNT_W-1:0];
      out_last_q   <= res_last;
    end else if (cmd_i.step) begin
      rem_q        <= sel_rest;
      out_status_q <= ST_OK;
      out_type_q   <= sel_type;
      out_cnt_q    <= count_ext[COUNT_W-1:0];
      out_total_q  <= total_ext[COUNT_W-1:0];
      out_last_q   <= (sel_rest == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_cnt_q, out_type_q, out_status_q};

  a_total_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == CW'($countones(used_q)))
    else $error("pair total disagrees with occupied slots");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && wr_en) |-> !full)
    else $error("insert into a full table");

  a_step_has_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rem_q != '0))
    else $error("enumerate step with no match left");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide || cmd_i.step) |-> (!m_valid_q || m_axis_tready))
    else $error("result overwrites an untaken result");

endmodule

// ===== sv/pair_binding_table.sv =====
// pair_binding_table: registry of (application id, type id) pairs held in
// SLOTS flop slots, cleared by reset and never shrunk.
//
// input stream (s_axis): one request per transfer; tuser carries the kind
// (register, authorize, enumerate), tdata the ids and the enumerate room.
// output stream (m_axis): one response per transfer; tlast marks the final
// response of a request. register, authorize and every error give a single
// response; an enumerate that succeeds gives one response per match, in
// slot order.
//
// sequence: a request is captured, compared against all slots in parallel with
// the match vectors registered, its match count is registered next, and then
// the first response is loaded into the output register. the block takes no
// new request until the last response of the current one is loaded; an
// enumerate loads its responses one after another. the slot compare, the count
// stage and the single output register are the registered steps on the way.
//
// reset empties the table and the output register; tready is registered and rises
// after release. a stalled receiver holds the pending response in the output register;
// one new request is still accepted and compared while that response waits.
module pair_binding_table
  import pbt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // app_id[63:0], type_id[127:64], room[134:128]
  input  logic [KIND_W-1:0]   s_axis_tuser,   // kind[1:0]
  // response stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // status[2:0], found_type[66:3],
                                              // match_count[71:67], total_pairs[76:72]
  output logic                m_axis_tlast    // last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: capture, compare, count, decide, then walk the matches
  pbt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // slot table, match logic and response register
  pbt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== bench/pair_binding_table_tb.sv =====
`timescale 1ns / 100ps

module pair_binding_table_tb
  import pbt_pkg::*;
();

  localparam int unsigned SLOTS = 16;
  localparam int unsigned APP_POOL = 4;
  localparam int unsigned TYPE_POOL = 24;
  localparam int unsigned RANDOM_REQS = 248;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [ID_W-1:0] ID_TOP = {1'b1, {(ID_W-1){1'b0}}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   app_id;
    logic [ID_W-1:0]   type_id;
    logic [ROOM_W-1:0] room;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_type;
    logic [COUNT_W-1:0]  match_count;
    logic [COUNT_W-1:0]  total_pairs;
    logic                last;
  } response_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0]   s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  pair_binding_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the binding table, updated as each request is accepted
  bit              slot_used [SLOTS];
  logic [ID_W-1:0] slot_app  [SLOTS];
  logic [ID_W-1:0] slot_type [SLOTS];
  int unsigned     pair_count = 0;

  request_t  pending_reqs[$];   // requests waiting for the driver
  response_t resp_expected[$];  // predicted responses, oldest first
  request_t  req_on_bus;

  logic [ID_W-1:0] app_pool  [APP_POOL];
  logic [ID_W-1:0] type_pool [TYPE_POOL];

  int unsigned reqs_queued = 0;
  int unsigned reqs_accepted = 0;
  int unsigned responses_checked = 0;
  int unsigned mismatches = 0;
  int unsigned longest_listing = 0;
  int unsigned full_refusals = 0;

  // one long stretch of the run has no idle cycles on either side
  wire steady = (reqs_accepted >= 110) && (reqs_accepted < 180);

  // work out every response one request causes and update the shadow table
  function automatic void predict_responses(request_t r);
    response_t rsp;
    int        hit;
    int        free_slot;
    int        n;
    int        k;
    hit = -1;
    free_slot = -1;
    n = 0;
    k = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_app[i] == r.app_id && slot_type[i] == r.type_id) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
      if (slot_used[i] && slot_app[i] == r.app_id) n++;
    end
    rsp = '0;
    rsp.last = 1'b1;
    rsp.status = ST_INVALID;
    case (r.kind)
      KIND_REGISTER: begin
        if (r.app_id == '0 || r.type_id == '0) begin
          rsp.status = ST_INVALID;
        end else if (hit >= 0) begin
          rsp.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          rsp.status = ST_NO_SPACE;
          full_refusals++;
        end else begin
          // lowest free slot takes the new pair
          slot_used[free_slot] = 1'b1;
          slot_app[free_slot] = r.app_id;
          slot_type[free_slot] = r.type_id;
          pair_count++;
          rsp.status = ST_OK;
        end
      end
      KIND_AUTHORIZE: begin
        if (r.app_id == '0 || r.type_id == '0) rsp.status = ST_INVALID;
        else if (hit >= 0) rsp.status = ST_OK;
        else rsp.status = ST_DENIED;
      end
      KIND_ENUMERATE: begin
        if (r.app_id == '0 || r.room == '0) begin
          rsp.status = ST_INVALID;
        end else if (n == 0) begin
          rsp.status = ST_NOT_FOUND;
        end else if (n > r.room) begin
          // caller too small: single response with the true count
          rsp.status = ST_NO_SPACE;
          rsp.match_count = n[COUNT_W-1:0];
        end else begin
          // one response per match, in slot order
          rsp.status = ST_OK;
          rsp.match_count = n[COUNT_W-1:0];
          rsp.total_pairs = pair_count[COUNT_W-1:0];
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_app[i] == r.app_id) begin
              k++;
              rsp.found_type = slot_type[i];
              rsp.last = (k == n);
              resp_expected.push_back(rsp);
            end
          end
          if (n > longest_listing) longest_listing = n;
          return;
        end
      end
      default: rsp.status = ST_INVALID;
    endcase
    rsp.total_pairs = pair_count[COUNT_W-1:0];
    resp_expected.push_back(rsp);
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed requests over a small pool of ids, so pairs repeat,
  // one application collects many types and the table fills; the rest is noise
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.kind = KIND_W'($urandom_range(3));
      r.app_id = ($urandom_range(3) == 0) ? '0 : random_id();
      r.type_id = ($urandom_range(3) == 0) ? '0 : random_id();
      r.room = ROOM_W'($urandom_range(127));
    end else begin
      if (pick < 40) r.kind = KIND_REGISTER;
      else if (pick < 68) r.kind = KIND_AUTHORIZE;
      else r.kind = KIND_ENUMERATE;
      if ($urandom_range(99) < 60) r.app_id = app_pool[0];
      else r.app_id = app_pool[$urandom_range(APP_POOL-1)];
      r.type_id = type_pool[$urandom_range(TYPE_POOL-1)];
      pick = $urandom_range(9);
      if (pick < 6) r.room = ROOM_W'($urandom_range(8, 1));
      else if (pick < 9) r.room = ROOM_W'($urandom_range(20, 9));
      else r.room = ROOM_W'($urandom_range(127, 64));
    end
    return r;
  endfunction

  function automatic void queue_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] app_id,
                                        logic [ID_W-1:0] type_id, logic [ROOM_W-1:0] room);
    request_t r;
    r.kind = kind;
    r.app_id = app_id;
    r.type_id = type_id;
    r.room = room;
    pending_reqs.push_back(r);
    reqs_queued++;
  endfunction

  // request driver: holds tvalid and the payload until accepted, idles at random
  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_responses(req_on_bus);
        reqs_accepted <= reqs_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 13)) begin
          nxt = pending_reqs.pop_front();
          req_on_bus <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, nxt.room, nxt.type_id, nxt.app_id};
          s_axis_tuser <= nxt.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // response monitor: stalls at random and checks every accepted response
  always @(posedge clk_i) begin : check_responses
    response_t want;
    response_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.found_type = m_axis_tdata[66:3];
        got.match_count = m_axis_tdata[71:67];
        got.total_pairs = m_axis_tdata[76:72];
        got.last = m_axis_tlast;
        if (resp_expected.size() == 0) begin
          $error("response with none expected: status %0d found_type %0h", got.status,
                 got.found_type);
          mismatches++;
        end else begin
          want = resp_expected.pop_front();
          responses_checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.found_type !== want.found_type) begin
            $error("found_type: expected %0h, got %0h", want.found_type, got.found_type);
            mismatches++;
          end
          if (got.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
            mismatches++;
          end
          if (got.total_pairs !== want.total_pairs) begin
            $error("total_pairs: expected %0d, got %0d", want.total_pairs, got.total_pairs);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 13);
    end
  end

  // ends the run when neither side has moved a request for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
             WATCHDOG_LIMIT, resp_expected.size());
    $display("pair_binding_table_tb failed");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < APP_POOL; i++) begin
      app_pool[i] = random_id();
      if (app_pool[i] == '0) app_pool[i] = ID_W'(1);
    end
    for (int i = 0; i < TYPE_POOL; i++) begin
      type_pool[i] = random_id();
      if (type_pool[i] == '0) type_pool[i] = ID_W'(1);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero ids and an empty table
    queue_request(KIND_REGISTER, '0, 64'd5, 7'd1);
    queue_request(KIND_REGISTER, ID_MAX, '0, 7'd1);
    queue_request(KIND_AUTHORIZE, '0, '0, 7'd0);
    queue_request(KIND_ENUMERATE, ID_MAX, '0, 7'd4);
    queue_request(KIND_ENUMERATE, '0, ID_MAX, 7'd4);
    queue_request(KIND_ENUMERATE, ID_MAX, ID_MAX, 7'd0);
    queue_request(KIND_AUTHORIZE, ID_MAX, ID_MAX, 7'd0);
    // first pairs, duplicate, authorize hit
    queue_request(KIND_REGISTER, ID_MAX, ID_MAX, 7'd127);
    queue_request(KIND_REGISTER, ID_MAX, ID_MAX, 7'd0);
    queue_request(KIND_AUTHORIZE, ID_MAX, ID_MAX, 7'd0);
    queue_request(KIND_REGISTER, ID_MAX, 64'd1, 7'd0);
    queue_request(KIND_REGISTER, 64'd1, ID_MAX, 7'd0);
    queue_request(KIND_REGISTER, ID_MAX, ID_TOP, 7'd0);
    queue_request(KIND_AUTHORIZE, 64'd1, 64'd1, 7'd0);
    // listing: exact fit, too small, wide room, single match, no match
    queue_request(KIND_ENUMERATE, ID_MAX, '0, 7'd3);
    queue_request(KIND_ENUMERATE, ID_MAX, ID_MAX, 7'd2);
    queue_request(KIND_ENUMERATE, ID_MAX, '0, 7'd64);
    queue_request(KIND_ENUMERATE, ID_MAX, '0, 7'd127);
    queue_request(KIND_ENUMERATE, 64'd1, '0, 7'd1);
    queue_request(KIND_ENUMERATE, ID_TOP, '0, 7'd9);
    // unused kind, all fields high and all low
    queue_request(KIND_UNUSED, ID_MAX, ID_MAX, 7'd127);
    queue_request(KIND_UNUSED, '0, '0, 7'd0);

    // hold off the sender until every directed response is back
    wait (reqs_accepted == reqs_queued && resp_expected.size() == 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pending_reqs.push_back(random_request());
      reqs_queued++;
    end

    wait (reqs_accepted == reqs_queued && resp_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (resp_expected.size() != 0) begin
      $error("%0d responses never arrived", resp_expected.size());
      mismatches++;
    end

    $display("%0d requests gave %0d checked responses; table ended with %0d of %0d pairs",
             reqs_accepted, responses_checked, pair_count, SLOTS);
    $display("longest listing %0d types, %0d registrations refused by a full table",
             longest_listing, full_refusals);
    if (mismatches == 0) begin
      $display("pair_binding_table_tb passed");
    end else begin
      $display("pair_binding_table_tb failed");
    end
    $finish;
  end

endmodule

// ===== pair_binding_table.f =====
sv/pbt_pkg.sv
sv/pbt_ctrl.sv
sv/pbt_datapath.sv
sv/pair_binding_table.sv
bench/pair_binding_table_tb.sv
